>>> rtl/gww_pkg.sv
// Shared types and constants for the greedy word wrap block.
`timescale 1ns / 1ps
package gww_pkg;

    localparam int MAX_WIDTH = 60;
    localparam int COL_W     = 6;
    localparam int HELD_AW   = $clog2(MAX_WIDTH);
    localparam int CHAR_W    = 8;
    localparam int COUNT_W   = 16;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [CHAR_W-1:0] in_char;
        logic              in_last;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  out_char;
        logic [COUNT_W-1:0] line_count;
        logic               out_last;
    } out_item_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } emit_t;

endpackage

>>> rtl/gww_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module gww_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 60,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/gww_seq.sv
// Wrap sequencer: per-byte control, line bookkeeping and held-word replay.
`timescale 1ns / 1ps
module gww_seq (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [gww_pkg::COL_W-1:0]      wrap_width,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  gww_pkg::in_item_t              s_payload,
    input  logic                           out_free,
    output gww_pkg::emit_t                 emit,
    output logic                           ram_we,
    output logic [gww_pkg::HELD_AW-1:0]    ram_waddr,
    output logic [gww_pkg::CHAR_W-1:0]     ram_wdata,
    output logic [gww_pkg::HELD_AW-1:0]    ram_raddr,
    input  logic [gww_pkg::CHAR_W-1:0]     ram_rdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PLACE,
        ST_BLANK,
        ST_WRD_RD,
        ST_WRD_OUT,
        ST_NL,
        ST_BRK
    } state_t;

    typedef enum logic [1:0] {
        RET_NL,
        RET_CHECK,
        RET_SETBLANK,
        RET_TERM
    } ret_t;

    localparam logic [gww_pkg::COL_W-1:0] WIDTH_MAX = gww_pkg::COL_W'(gww_pkg::MAX_WIDTH);
    localparam logic [gww_pkg::COL_W-1:0] WIDTH_MIN = gww_pkg::COL_W'(1);

    state_t                          state_reg, state_next;
    ret_t                            ret_reg, ret_next;
    logic                            term_reg, term_next;
    logic [gww_pkg::CHAR_W-1:0]      char_reg, char_next;
    logic                            last_reg, last_next;
    logic [gww_pkg::COL_W-1:0]       held_count_reg, held_count_next;
    logic [gww_pkg::CHAR_W-1:0]      held_blank_reg, held_blank_next;
    logic                            pending_reg, pending_next;
    logic [gww_pkg::COL_W-1:0]       line_len_reg, line_len_next;
    logic [gww_pkg::COUNT_W-1:0]     lines_reg, lines_next;
    logic                            stopped_reg, stopped_next;
    logic [gww_pkg::COL_W-1:0]       idx_reg, idx_next;

    logic [gww_pkg::COL_W-1:0]       eff_width;
    logic                            is_blank;
    logic [gww_pkg::COUNT_W-1:0]     lines_inc;

    always_comb begin
        priority if (wrap_width == '0) begin
            eff_width = WIDTH_MIN;
        end else if (wrap_width > WIDTH_MAX) begin
            eff_width = WIDTH_MAX;
        end else begin
            eff_width = wrap_width;
        end
    end

    assign is_blank  = (char_reg == gww_pkg::CHAR_SPACE) || (char_reg == gww_pkg::CHAR_TAB);
    assign lines_inc = (lines_reg != gww_pkg::COUNT_MAX) ? lines_reg + 1'b1 : lines_reg;

    assign ram_waddr = held_count_reg[gww_pkg::HELD_AW-1:0];
    assign ram_wdata = char_reg;
    assign ram_raddr = idx_reg[gww_pkg::HELD_AW-1:0];

    always_comb begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        term_next       = term_reg;
        char_next       = char_reg;
        last_next       = last_reg;
        held_count_next = held_count_reg;
        held_blank_next = held_blank_reg;
        pending_next    = pending_reg;
        line_len_next   = line_len_reg;
        lines_next      = lines_reg;
        stopped_next    = stopped_reg;
        idx_next        = idx_reg;
        s_ready         = 1'b0;
        ram_we          = 1'b0;
        emit            = '0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    char_next  = s_payload.in_char;
                    last_next  = s_payload.in_last;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                priority if (stopped_reg || char_reg == gww_pkg::CHAR_NUL) begin
                    stopped_next = 1'b1;
                    state_next   = last_reg ? ST_BLANK : ST_IDLE;
                    ret_next     = RET_TERM;
                end else if (char_reg == gww_pkg::CHAR_LF) begin
                    ret_next   = RET_NL;
                    state_next = ST_BLANK;
                end else if (line_len_reg >= eff_width) begin
                    state_next = ST_BRK;
                end else if (is_blank) begin
                    ret_next   = RET_SETBLANK;
                    state_next = ST_BLANK;
                end else begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE: begin
                if (pending_reg && held_count_reg < WIDTH_MAX) begin
                    ram_we          = 1'b1;
                    held_count_next = held_count_reg + 1'b1;
                    line_len_next   = line_len_reg + 1'b1;
                    state_next      = last_reg ? ST_BLANK : ST_IDLE;
                    ret_next        = RET_TERM;
                end else if (out_free) begin
                    emit.valid         = 1'b1;
                    emit.item.out_char = char_reg;
                    line_len_next      = line_len_reg + 1'b1;
                    state_next         = last_reg ? ST_BLANK : ST_IDLE;
                    ret_next           = RET_TERM;
                end
            end
            ST_BLANK: begin
                if (!pending_reg) begin
                    state_next = ST_WRD_RD;
                end else if (out_free) begin
                    emit.valid         = 1'b1;
                    emit.item.out_char = held_blank_reg;
                    pending_next       = 1'b0;
                    state_next         = ST_WRD_RD;
                end
            end
            ST_WRD_RD: begin
                if (idx_reg >= held_count_reg || idx_reg >= WIDTH_MAX) begin
                    held_count_next = '0;
                    idx_next        = '0;
                    unique case (ret_reg)
                        RET_NL:    state_next = ST_NL;
                        RET_CHECK: state_next = ST_CHECK;
                        RET_SETBLANK: begin
                            pending_next    = 1'b1;
                            held_blank_next = char_reg;
                            line_len_next   = line_len_reg + 1'b1;
                            state_next      = last_reg ? ST_BLANK : ST_IDLE;
                            ret_next        = RET_TERM;
                        end
                        RET_TERM: begin
                            term_next  = 1'b1;
                            state_next = ST_NL;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end else begin
                    state_next = ST_WRD_OUT;
                end
            end
            ST_WRD_OUT: begin
                if (out_free) begin
                    emit.valid         = 1'b1;
                    emit.item.out_char = ram_rdata;
                    idx_next           = idx_reg + 1'b1;
                    state_next         = ST_WRD_RD;
                end
            end
            ST_NL: begin
                if (out_free) begin
                    emit.valid = 1'b1;
                    if (term_reg) begin
                        emit.item.out_char   = gww_pkg::CHAR_NUL;
                        emit.item.line_count = lines_reg;
                        emit.item.out_last   = 1'b1;
                        term_next            = 1'b0;
                        held_count_next      = '0;
                        held_blank_next      = '0;
                        pending_next         = 1'b0;
                        line_len_next        = '0;
                        lines_next           = gww_pkg::COUNT_W'(1);
                        stopped_next         = 1'b0;
                        state_next           = ST_IDLE;
                    end else begin
                        emit.item.out_char = gww_pkg::CHAR_LF;
                        lines_next         = lines_inc;
                        line_len_next      = '0;
                        state_next         = last_reg ? ST_BLANK : ST_IDLE;
                        ret_next           = RET_TERM;
                    end
                end
            end
            ST_BRK: begin
                if (out_free) begin
                    emit.valid         = 1'b1;
                    emit.item.out_char = gww_pkg::CHAR_LF;
                    lines_next         = lines_inc;
                    if (pending_reg) begin
                        pending_next  = 1'b0;
                        line_len_next = held_count_reg;
                        ret_next      = RET_CHECK;
                        state_next    = ST_WRD_RD;
                    end else begin
                        line_len_next = '0;
                        state_next    = ST_CHECK;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ret_reg        <= RET_TERM;
            term_reg       <= 1'b0;
            held_count_reg <= '0;
            held_blank_reg <= '0;
            pending_reg    <= 1'b0;
            line_len_reg   <= '0;
            lines_reg      <= gww_pkg::COUNT_W'(1);
            stopped_reg    <= 1'b0;
            idx_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            term_reg       <= term_next;
            held_count_reg <= held_count_next;
            held_blank_reg <= held_blank_next;
            pending_reg    <= pending_next;
            line_len_reg   <= line_len_next;
            lines_reg      <= lines_next;
            stopped_reg    <= stopped_next;
            idx_reg        <= idx_next;
        end
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule

>>> rtl/greedy_word_wrap.sv
// Greedy word wrap top level: width register, output register, sequencer and held-word RAM.
//
// Bytes of one text field enter on the s_ channel (valid/ready) and leave re-wrapped on
// the m_ channel (valid/ready). A byte marked in_last is followed by any held text and
// then a zero terminator with out_last set and the field's line count.
// cfg_wr_en/cfg_wr_data set the column width; write it only while the block is idle.
// s_ready is high only while the sequencer waits for a byte; each byte is worked on alone.
// A plain byte passes the check and place steps before the next byte is accepted; an emitted
// byte goes through the output register to the m_ channel. A blank or a newline first replays
// any held word, with one RAM read and one emit per held byte. A break on a full line emits a
// newline and, when a word is held, moves the held word down to the new line. The byte marked
// last adds the flush of held text and the terminator. A stalled receiver holds the output
// register and the sequencer waits in its current step; nothing is lost.
// Reset clears the field state, restores a width of 60 and empties the output register.
`timescale 1ns / 1ps
module greedy_word_wrap (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [gww_pkg::COL_W-1:0]     cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  gww_pkg::in_item_t             s_payload,
    output logic                          m_valid,
    input  logic                          m_ready,
    output gww_pkg::out_item_t            m_payload
);

    logic [gww_pkg::COL_W-1:0]   width_reg;
    logic                        m_valid_reg;
    gww_pkg::out_item_t          m_payload_reg;
    logic                        out_free;
    gww_pkg::emit_t              emit;
    logic                        ram_we;
    logic [gww_pkg::HELD_AW-1:0] ram_waddr;
    logic [gww_pkg::CHAR_W-1:0]  ram_wdata;
    logic [gww_pkg::HELD_AW-1:0] ram_raddr;
    logic [gww_pkg::CHAR_W-1:0]  ram_rdata;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= gww_pkg::COL_W'(gww_pkg::MAX_WIDTH);
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                width_reg <= cfg_wr_data;
            end
            if (out_free) begin
                m_valid_reg <= emit.valid;
            end
        end
        if (emit.valid) begin
            m_payload_reg <= emit.item;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    gww_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wrap_width (width_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .out_free   (out_free),
        .emit       (emit),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    gww_ram #(
        .WIDTH (gww_pkg::CHAR_W),
        .DEPTH (gww_pkg::MAX_WIDTH)
    ) u_held_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

endmodule
